>>> design/htmr_pkg.sv
// Shared types and constants for the handheld console timer.
// Holds action codes, register selects and the clock-select period table.
// No dependencies.
package htmr_pkg;

  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_WRITE = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  localparam logic [1:0] REG_DIV  = 2'd0;
  localparam logic [1:0] REG_TIMA = 2'd1;
  localparam logic [1:0] REG_TMA  = 2'd2;
  localparam logic [1:0] REG_TAC  = 2'd3;

  localparam int unsigned CNT_W  = 9;   // countdown holds 1..256
  localparam int unsigned LEFT_W = 10;  // signed countdown remainder

  localparam int unsigned TAC_ENABLE_BIT = 2;

  // Countdown length for each clock select.
  function automatic logic [CNT_W-1:0] period_of(input logic [1:0] sel);
    logic [CNT_W-1:0] p;
    case (sel)
      2'd0:    p = 9'd256;
      2'd1:    p = 9'd4;
      2'd2:    p = 9'd16;
      2'd3:    p = 9'd64;
      default: p = 9'd256;
    endcase
    return p;
  endfunction

endpackage

>>> design/handheld_console_timer.sv
// Handheld console timer: divider, counter, modulo and control registers (uses htmr_pkg).
// Each beat passes IDLE, EXEC and DONE; a tick whose countdown expires runs EXPIRE
// once per counter increment (up to 4) before DONE. DONE waits for a free output register.
// One beat at a time: a new beat is taken only in IDLE, so the countdown loop through the shared
// adder holds off the next beat. A finished result may wait in the output register while the next beat
// is taken. Reset (rst_ni low, asynchronous) clears all registers, countdown to 256.
module handheld_console_timer #(
  parameter int unsigned DIVIDER_PERIOD = 64  // range 16..255
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [7:0] write_data, [11:8] cycle_count, [15:12] zero
  input  logic [3:0]  s_axis_tuser,   // [1:0] action, [3:2] reg_select
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // [7:0] read_data, [8] timer_interrupt, [15:9] zero
);

  typedef enum logic [1:0] {
    ST_IDLE,    // wait for an input beat
    ST_EXEC,    // apply read/write, advance divider, subtract tick from countdown
    ST_EXPIRE,  // one counter increment per cycle until countdown is positive
    ST_DONE     // hand the result to the output register
  } state_e;

  state_e state_q;

  // Latched input beat.
  logic [1:0] action_q;
  logic [1:0] sel_q;
  logic [7:0] wdata_q;
  logic [3:0] cycles_q;

  // Timer registers.
  logic [7:0]                     div_q;
  logic [7:0]                     presc_q;
  logic [7:0]                     tima_q;
  logic [7:0]                     tma_q;
  logic [7:0]                     tac_q;
  logic [htmr_pkg::CNT_W-1:0]     cnt_q;
  logic signed [htmr_pkg::LEFT_W-1:0] left_q;

  // Result under construction and output register.
  logic [7:0] rd_q;
  logic       irq_q;
  logic       out_valid_q;
  logic [7:0] out_rd_q;
  logic       out_irq_q;

  logic in_fire;
  logic out_free;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, out_irq_q, out_rd_q};

  // Shared adder: countdown minus tick length in EXEC, remainder plus period in EXPIRE.
  logic signed [htmr_pkg::LEFT_W-1:0] op_a;
  logic signed [htmr_pkg::LEFT_W-1:0] op_b;
  logic signed [htmr_pkg::LEFT_W-1:0] sum;
  logic                               sum_pos;

  always_comb begin
    if (state_q == ST_EXPIRE) begin
      op_a = left_q;
      op_b = signed'({1'b0, htmr_pkg::period_of(tac_q[1:0])});
    end else begin
      op_a = signed'({1'b0, cnt_q});
      op_b = -signed'(htmr_pkg::LEFT_W'(cycles_q));
    end
  end

  assign sum     = op_a + op_b;
  assign sum_pos = !sum[htmr_pkg::LEFT_W-1] && (sum != '0);

  // Divider prescaler: the sum stays below twice the period, so one subtract wraps it.
  logic [8:0] presc_sum;
  assign presc_sum = {1'b0, presc_q} + 9'(cycles_q);

  // Counter increment with wrap to the modulo value.
  logic [8:0] tima_inc;
  assign tima_inc = {1'b0, tima_q} + 9'd1;

  // Read mux.
  logic [7:0] rd_mux;
  always_comb begin
    case (sel_q)
      htmr_pkg::REG_DIV:  rd_mux = div_q;
      htmr_pkg::REG_TIMA: rd_mux = tima_q;
      htmr_pkg::REG_TMA:  rd_mux = tma_q;
      htmr_pkg::REG_TAC:  rd_mux = tac_q;
      default:            rd_mux = tac_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      div_q       <= '0;
      presc_q     <= '0;
      tima_q      <= '0;
      tma_q       <= '0;
      tac_q       <= '0;
      cnt_q       <= 9'd256;
      left_q      <= '0;
      rd_q        <= '0;
      irq_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_rd_q    <= '0;
      out_irq_q   <= 1'b0;
      action_q    <= '0;
      sel_q       <= '0;
      wdata_q     <= '0;
      cycles_q    <= '0;
    end else begin
      // Drop the output beat once taken; in DONE the refill below takes its place.
      if (out_valid_q && m_axis_tready && (state_q != ST_DONE)) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            action_q <= s_axis_tuser[1:0];
            sel_q    <= s_axis_tuser[3:2];
            wdata_q  <= s_axis_tdata[7:0];
            cycles_q <= s_axis_tdata[11:8];
            state_q  <= ST_EXEC;
          end
        end

        ST_EXEC: begin
          rd_q    <= '0;
          irq_q   <= 1'b0;
          state_q <= ST_DONE;
          case (action_q)
            htmr_pkg::ACT_TICK: begin
              // Advance the divider once per full period.
              if (presc_sum >= 9'(DIVIDER_PERIOD)) begin
                presc_q <= 8'(presc_sum - 9'(DIVIDER_PERIOD));
                div_q   <= div_q + 8'd1;
              end else begin
                presc_q <= presc_sum[7:0];
              end
              // Hold the countdown while the timer is disabled.
              if (tac_q[htmr_pkg::TAC_ENABLE_BIT]) begin
                if (sum_pos) begin
                  cnt_q <= sum[htmr_pkg::CNT_W-1:0];
                end else begin
                  left_q  <= sum;
                  state_q <= ST_EXPIRE;
                end
              end
            end
            htmr_pkg::ACT_WRITE: begin
              case (sel_q)
                htmr_pkg::REG_DIV:  div_q  <= '0;
                htmr_pkg::REG_TIMA: tima_q <= wdata_q;
                htmr_pkg::REG_TMA:  tma_q  <= wdata_q;
                htmr_pkg::REG_TAC: begin
                  tac_q <= wdata_q;
                  cnt_q <= htmr_pkg::period_of(wdata_q[1:0]);
                end
                default: tac_q <= wdata_q;
              endcase
            end
            htmr_pkg::ACT_READ: begin
              rd_q <= rd_mux;
            end
            default: begin
              // Unused action code: no effect.
            end
          endcase
        end

        ST_EXPIRE: begin
          // One increment per pass; reload from modulo on wrap.
          if (tima_inc[8]) begin
            tima_q <= tma_q;
            irq_q  <= 1'b1;
          end else begin
            tima_q <= tima_inc[7:0];
          end
          if (sum_pos) begin
            cnt_q   <= sum[htmr_pkg::CNT_W-1:0];
            state_q <= ST_DONE;
          end else begin
            left_q <= sum;
          end
        end

        ST_DONE: begin
          // Hold until the output register is free or being drained.
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_rd_q    <= rd_q;
            out_irq_q   <= irq_q;
            state_q     <= ST_IDLE;
          end
        end

        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Countdown always stays within 1..256.
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != '0) && (cnt_q <= 9'd256))
    else $error("countdown out of range");

  // Prescaler never reaches the divider period.
  a_presc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    9'(presc_q) < 9'(DIVIDER_PERIOD))
    else $error("prescaler not wrapped");

  // The expiry loop runs only on an enabled tick with a non-positive remainder.
  a_expire_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EXPIRE) |->
      (tac_q[htmr_pkg::TAC_ENABLE_BIT] && (action_q == htmr_pkg::ACT_TICK) &&
       (left_q[htmr_pkg::LEFT_W-1] || (left_q == '0))))
    else $error("expiry loop entered wrongly");

  // A new result is loaded only from the DONE state.
  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == ST_DONE))
    else $error("output loaded outside DONE");

endmodule

>>> tb/handheld_console_timer_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the handheld console timer: directed and random beats.
// Uses an in-bench model of the divider, counter and countdown. Depends on htmr_pkg.
module handheld_console_timer_test;
  import htmr_pkg::*;

  localparam int unsigned DIV_PERIOD  = 64;
  localparam int unsigned RANDOM_BEATS = 1525;      // spread across the four phases
  localparam int unsigned DRAIN_CYCLES = 20;        // extra wait after the last expected result
  localparam int unsigned CYCLE_LIMIT  = 400000;

  // Action code that the block ignores.
  localparam logic [1:0] ACT_NONE = 2'd3;

  // Idle percentages for the backpressure phases.
  localparam int unsigned GAP_OFF  = 0;
  localparam int unsigned GAP_ONE  = 45;
  localparam int unsigned GAP_BOTH = 28;

  typedef struct packed {
    logic [1:0] action;
    logic [1:0] reg_sel;
    logic [7:0] wdata;
    logic [3:0] cycles;
  } timer_beat_t;

  typedef struct packed {
    logic [7:0] rd;
    logic       irq;
  } timer_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;   // [7:0] write_data, [11:8] cycle_count, [15:12] zero
  logic [3:0]  s_axis_tuser = '0;   // [1:0] action, [3:2] reg_select
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;        // [7:0] read_data, [8] timer_interrupt, [15:9] zero

  handheld_console_timer #(
    .DIVIDER_PERIOD(DIV_PERIOD)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #6 clk_i = ~clk_i;

  // Stimulus and scoreboard storage.
  timer_beat_t   pending_beats[$];
  timer_result_t expected_results[$];
  timer_beat_t   beat_on_bus = '0;
  logic          in_taken = 1'b0;

  int unsigned send_gap_pct = GAP_OFF;
  int unsigned recv_gap_pct = GAP_OFF;
  int unsigned mismatch_count = 0;
  int unsigned beats_accepted = 0;
  int unsigned results_checked = 0;
  int unsigned irq_results = 0;
  int unsigned cycle_count = 0;

  // Model state of the timer.
  logic [7:0] div_q;
  logic [7:0] prescale_q;
  logic [7:0] tima_q;
  logic [7:0] tma_q;
  logic [7:0] tac_q;
  logic [8:0] countdown_q;

  // Countdown length for a clock select: 256, 4, 16, 64.
  function automatic int select_cycles(input logic [1:0] sel);
    case (sel)
      2'd1:    return 4;
      2'd2:    return 16;
      2'd3:    return 64;
      default: return 256;
    endcase
  endfunction

  function automatic void timer_reset_state();
    div_q       = '0;
    prescale_q  = '0;
    tima_q      = '0;
    tma_q       = '0;
    tac_q       = '0;
    countdown_q = 9'd256;
  endfunction

  // Advance the timer model by one beat and return what the block should answer.
  function automatic timer_result_t timer_apply(input timer_beat_t b);
    timer_result_t r;
    int            pre;
    int            left;
    int            per;
    r = '0;
    case (b.action)
      ACT_TICK: begin
        pre = int'(prescale_q) + int'(b.cycles);
        if (pre >= DIV_PERIOD) begin
          pre   = pre - DIV_PERIOD;
          div_q = div_q + 8'd1;
        end
        prescale_q = pre[7:0];
        if (tac_q[TAC_ENABLE_BIT]) begin
          left = int'(countdown_q) - int'(b.cycles);
          per  = select_cycles(tac_q[1:0]);
          // Each expiry adds one period back and bumps the counter.
          while (left <= 0) begin
            left   = left + per;
            tima_q = tima_q + 8'd1;
            if (tima_q == 8'd0) begin
              tima_q = tma_q;
              r.irq  = 1'b1;
            end
          end
          countdown_q = left[8:0];
        end
      end
      ACT_WRITE: begin
        case (b.reg_sel)
          REG_DIV:  div_q = '0;          // data is ignored, prescaler untouched
          REG_TIMA: tima_q = b.wdata;
          REG_TMA:  tma_q = b.wdata;
          default: begin
            tac_q       = b.wdata;
            countdown_q = 9'(select_cycles(b.wdata[1:0]));
          end
        endcase
      end
      ACT_READ: begin
        case (b.reg_sel)
          REG_DIV:  r.rd = div_q;
          REG_TIMA: r.rd = tima_q;
          REG_TMA:  r.rd = tma_q;
          default:  r.rd = tac_q;
        endcase
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic timer_beat_t mk_beat(input logic [1:0] act, input logic [1:0] sel,
                                          input logic [7:0] data, input logic [3:0] cyc);
    timer_beat_t b;
    b.action  = act;
    b.reg_sel = sel;
    b.wdata   = data;
    b.cycles  = cyc;
    return b;
  endfunction

  // Mostly ticks and enabled-timer writes so the counter wraps often;
  // divider clears stay rare so the divider can climb.
  function automatic timer_beat_t random_beat();
    timer_beat_t b;
    int unsigned pick;
    b.action  = ACT_TICK;
    b.reg_sel = 2'($urandom_range(0, 3));
    b.wdata   = 8'($urandom_range(0, 255));
    b.cycles  = ($urandom_range(0, 3) == 0) ? 4'd15 : 4'($urandom_range(0, 15));
    pick = $urandom_range(0, 99);
    if (pick < 58) begin
      b.action = ACT_TICK;
    end else if (pick < 72) begin
      b.action = ACT_WRITE;
      pick = $urandom_range(0, 99);
      if (pick < 2) begin
        b.reg_sel = REG_DIV;
      end else if (pick < 40) begin
        b.reg_sel = REG_TAC;
        if ($urandom_range(0, 99) < 85) b.wdata[TAC_ENABLE_BIT] = 1'b1;
      end else if (pick < 75) begin
        b.reg_sel = REG_TIMA;
        if ($urandom_range(0, 1) == 0) b.wdata = 8'($urandom_range(8'hF0, 8'hFF));
      end else begin
        b.reg_sel = REG_TMA;
      end
    end else if (pick < 97) begin
      b.action = ACT_READ;
    end else begin
      b.action = ACT_NONE;
    end
    return b;
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("MISMATCH @%0t: %s got 0x%04h want 0x%04h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // Driver: present a new beat at the falling edge once the previous one was taken.
  always @(negedge clk_i) begin : drive_proc
    timer_beat_t b;
    if (rst_ni) begin
      if (!s_axis_tvalid || in_taken) begin
        if (pending_beats.size() > 0 && $urandom_range(0, 99) >= send_gap_pct) begin
          b = pending_beats.pop_front();
          beat_on_bus   <= b;
          s_axis_tdata  <= {4'b0000, b.cycles, b.wdata};
          s_axis_tuser  <= {b.reg_sel, b.action};
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      m_axis_tready <= ($urandom_range(0, 99) >= recv_gap_pct);
    end
  end

  // Monitor: predict on each accepted input beat, check each accepted output beat.
  always @(posedge clk_i) begin : check_proc
    timer_result_t want;
    in_taken <= s_axis_tvalid && s_axis_tready;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_results.push_back(timer_apply(beat_on_bus));
        beats_accepted++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result beat with nothing pending", m_axis_tdata, 16'h0000);
        end else begin
          want = expected_results.pop_front();
          results_checked++;
          if (want.irq) irq_results++;
          if (m_axis_tdata[7:0] !== want.rd)
            report_mismatch("read_data", {8'h00, m_axis_tdata[7:0]}, {8'h00, want.rd});
          if (m_axis_tdata[8] !== want.irq)
            report_mismatch("timer_interrupt", {15'h0, m_axis_tdata[8]}, {15'h0, want.irq});
          if (m_axis_tdata[15:9] !== 7'h00)
            report_mismatch("padding bits", {9'h0, m_axis_tdata[15:9]}, 16'h0000);
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still pending",
               cycle_count, expected_results.size());
      $display("Verification failed");
      $finish;
    end
  end

  // Hold until the driver has handed off every queued beat.
  task automatic wait_stimulus_drained();
    @(posedge clk_i);
    while (pending_beats.size() != 0 || s_axis_tvalid) @(posedge clk_i);
  endtask

  initial begin : stim_proc
    int unsigned phase;
    int unsigned n;
    timer_reset_state();

    // Directed: reset values, each clock select, wraps, disabled hold, ignored code.
    pending_beats.push_back(mk_beat(ACT_READ,  REG_DIV,  8'h00, 4'h0));
    pending_beats.push_back(mk_beat(ACT_READ,  REG_TIMA, 8'hFF, 4'hF));
    pending_beats.push_back(mk_beat(ACT_READ,  REG_TMA,  8'h00, 4'h0));
    pending_beats.push_back(mk_beat(ACT_READ,  REG_TAC,  8'hFF, 4'hF));
    pending_beats.push_back(mk_beat(ACT_TICK,  REG_TAC,  8'hFF, 4'hF));  // timer off
    pending_beats.push_back(mk_beat(ACT_WRITE, REG_TAC,  8'h05, 4'h0));  // enable, period 4
    pending_beats.push_back(mk_beat(ACT_TICK,  REG_DIV,  8'h00, 4'h0));  // zero-length tick
    pending_beats.push_back(mk_beat(ACT_WRITE, REG_TIMA, 8'hFE, 4'hF));
    pending_beats.push_back(mk_beat(ACT_WRITE, REG_TMA,  8'hA5, 4'h0));
    pending_beats.push_back(mk_beat(ACT_TICK,  REG_DIV,  8'h00, 4'hF));  // several expiries, wrap
    pending_beats.push_back(mk_beat(ACT_READ,  REG_TIMA, 8'h00, 4'h0));
    pending_beats.push_back(mk_beat(ACT_WRITE, REG_TIMA, 8'hFF, 4'h0));
    pending_beats.push_back(mk_beat(ACT_TICK,  REG_DIV,  8'h00, 4'hF));
    pending_beats.push_back(mk_beat(ACT_WRITE, REG_TAC,  8'h04, 4'h0));  // period 256
    pending_beats.push_back(mk_beat(ACT_TICK,  REG_DIV,  8'h00, 4'hF));
    pending_beats.push_back(mk_beat(ACT_WRITE, REG_TAC,  8'h06, 4'h0));  // period 16
    pending_beats.push_back(mk_beat(ACT_TICK,  REG_DIV,  8'h00, 4'hF));
    pending_beats.push_back(mk_beat(ACT_TICK,  REG_DIV,  8'h00, 4'hF));
    pending_beats.push_back(mk_beat(ACT_WRITE, REG_TAC,  8'h07, 4'h0));  // period 64
    pending_beats.push_back(mk_beat(ACT_TICK,  REG_DIV,  8'h00, 4'hF));
    pending_beats.push_back(mk_beat(ACT_WRITE, REG_TAC,  8'hFB, 4'h0));  // disabled, countdown held
    pending_beats.push_back(mk_beat(ACT_TICK,  REG_DIV,  8'h00, 4'hF));
    pending_beats.push_back(mk_beat(ACT_WRITE, REG_DIV,  8'hFF, 4'hF));  // clear, data ignored
    pending_beats.push_back(mk_beat(ACT_READ,  REG_DIV,  8'h00, 4'h0));
    pending_beats.push_back(mk_beat(ACT_NONE,  REG_TAC,  8'hFF, 4'hF));  // ignored code
    pending_beats.push_back(mk_beat(ACT_WRITE, REG_TMA,  8'h00, 4'h0));

    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Random beats over four backpressure phases.
    for (phase = 0; phase < 4; phase++) begin
      wait_stimulus_drained();
      case (phase)
        0: begin send_gap_pct = GAP_OFF;  recv_gap_pct = GAP_OFF;  end
        1: begin send_gap_pct = GAP_ONE;  recv_gap_pct = GAP_OFF;  end
        2: begin send_gap_pct = GAP_OFF;  recv_gap_pct = GAP_ONE;  end
        default: begin send_gap_pct = GAP_BOTH; recv_gap_pct = GAP_BOTH; end
      endcase
      for (n = 0; n < RANDOM_BEATS / 4; n++) pending_beats.push_back(random_beat());
    end
    wait_stimulus_drained();

    // Drain the results, then allow a few more cycles for stray beats.
    @(negedge clk_i);
    while (expected_results.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (expected_results.size() != 0)
      report_mismatch("results never arrived", 16'(expected_results.size()), 16'h0000);

    $display("Checked %0d of %0d beats (directed plus random ticks, writes, reads)",
             results_checked, beats_accepted);
    $display("under four backpressure phases; %0d results carried a timer interrupt, %0d mismatches",
             irq_results, mismatch_count);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
